/* design/viatmr_pkg.sv */
package viatmr_pkg;

    // Transaction operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Register offsets
    localparam logic [3:0] REG_ORB   = 4'd0;
    localparam logic [3:0] REG_ORA   = 4'd1;
    localparam logic [3:0] REG_DDRB  = 4'd2;
    localparam logic [3:0] REG_DDRA  = 4'd3;
    localparam logic [3:0] REG_T1CL  = 4'd4;
    localparam logic [3:0] REG_T1CH  = 4'd5;
    localparam logic [3:0] REG_T1LL  = 4'd6;
    localparam logic [3:0] REG_T1LH  = 4'd7;
    localparam logic [3:0] REG_T2CL  = 4'd8;
    localparam logic [3:0] REG_T2CH  = 4'd9;
    localparam logic [3:0] REG_SR    = 4'd10;
    localparam logic [3:0] REG_ACR   = 4'd11;
    localparam logic [3:0] REG_PCR   = 4'd12;
    localparam logic [3:0] REG_IFR   = 4'd13;
    localparam logic [3:0] REG_IER   = 4'd14;
    localparam logic [3:0] REG_ORANH = 4'd15;

    // Flag bit positions and control bits
    localparam int FLAG_T1      = 6;
    localparam int FLAG_T2      = 5;
    localparam int ACR_T1_FREE  = 6;
    localparam int ACR_T2_PULSE = 5;

    localparam logic [7:0]  BYTE_ONES = 8'hFF;
    localparam logic [15:0] WORD_ONES = 16'hFFFF;

endpackage

/* design/via_timer_port_registers_top.sv */
// Channel   | Valid    | Stall    | Payload
// ----------+----------+----------+---------------------------------------------------
// input     | i_valid  | o_stall  | i_operation, i_address, i_write_data, i_port_*_pins
// result    | o_valid  | i_stall  | o_read_data, o_port_a_drive, o_port_b_drive, o_irq
//
// One transaction per cycle while the result is not stalled; a transaction passes the input
// register, then the register file and timers update together with the result register.
// Reset (i_rst_n low, synchronous) empties both stages and loads register reset values.
// A stalled result holds; the input register keeps taking transactions until it is
// full behind a stalled result, so o_stall rises only while i_stall is high.
module via_timer_port_registers_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_operation,
    input  logic [3:0] i_address,
    input  logic [7:0] i_write_data,
    input  logic [7:0] i_port_a_pins,
    input  logic [7:0] i_port_b_pins,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_read_data,
    output logic [7:0] o_port_a_drive,
    output logic [7:0] o_port_b_drive,
    output logic       o_irq
);
    import viatmr_pkg::*;

    // Input stage
    logic       r_in_valid;
    logic [1:0] r_op;
    logic [3:0] r_addr;
    logic [7:0] r_wdata;
    logic [7:0] r_pa_pins;
    logic [7:0] r_pb_pins;

    // Result stage
    logic       r_out_valid;
    logic [7:0] r_read_data;
    logic [7:0] r_pa_drive;
    logic [7:0] r_pb_drive;
    logic       r_irq;

    // Register file and timers
    logic [7:0]  r_pa_latch,  n_pa_latch;
    logic [7:0]  r_pb_latch,  n_pb_latch;
    logic [7:0]  r_pa_dir,    n_pa_dir;
    logic [7:0]  r_pb_dir,    n_pb_dir;
    logic [15:0] r_t1_latch,  n_t1_latch;
    logic [15:0] r_t1_count,  n_t1_count;
    logic [15:0] r_t2_latch,  n_t2_latch;
    logic [15:0] r_t2_count,  n_t2_count;
    logic        r_t1_active, n_t1_active;
    logic        r_t2_active, n_t2_active;
    logic [7:0]  r_shift,     n_shift;
    logic [7:0]  r_acr,       n_acr;
    logic [7:0]  r_pcr,       n_pcr;
    logic [6:0]  r_flags,     n_flags;
    logic [6:0]  r_enables,   n_enables;
    logic [7:0]  n_read_data;

    logic advance;
    logic take_in;
    logic pending;
    logic [7:0] pa_value;
    logic [7:0] pb_value;

    // Handshake
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign take_in = i_valid && !o_stall;

    // Port read values: latch on output bits, pins on input bits
    assign pa_value = (r_pa_latch & r_pa_dir) | (r_pa_pins & ~r_pa_dir);
    assign pb_value = (r_pb_latch & r_pb_dir) | (r_pb_pins & ~r_pb_dir);

    // Next state and read data for the transaction in the input register
    always_comb begin
        n_pa_latch  = r_pa_latch;
        n_pb_latch  = r_pb_latch;
        n_pa_dir    = r_pa_dir;
        n_pb_dir    = r_pb_dir;
        n_t1_latch  = r_t1_latch;
        n_t1_count  = r_t1_count;
        n_t2_latch  = r_t2_latch;
        n_t2_count  = r_t2_count;
        n_t1_active = r_t1_active;
        n_t2_active = r_t2_active;
        n_shift     = r_shift;
        n_acr       = r_acr;
        n_pcr       = r_pcr;
        n_flags     = r_flags;
        n_enables   = r_enables;
        n_read_data = 8'h00;
        unique case (r_op)
            OP_READ: begin
                unique case (r_addr)
                    REG_ORB:   n_read_data = pb_value;
                    REG_ORA:   n_read_data = pa_value;
                    REG_DDRB:  n_read_data = r_pb_dir;
                    REG_DDRA:  n_read_data = r_pa_dir;
                    REG_T1CL: begin
                        n_read_data       = r_t1_count[7:0];
                        n_flags[FLAG_T1]  = 1'b0;
                    end
                    REG_T1CH:  n_read_data = r_t1_count[15:8];
                    REG_T1LL:  n_read_data = r_t1_latch[7:0];
                    REG_T1LH:  n_read_data = r_t1_latch[15:8];
                    REG_T2CL: begin
                        n_read_data       = r_t2_count[7:0];
                        n_flags[FLAG_T2]  = 1'b0;
                    end
                    REG_T2CH:  n_read_data = r_t2_count[15:8];
                    REG_SR:    n_read_data = r_shift;
                    REG_ACR:   n_read_data = r_acr;
                    REG_PCR:   n_read_data = r_pcr;
                    // bit 7 is the master bit as left by the previous transaction
                    REG_IFR:   n_read_data = {|(r_flags & r_enables), r_flags};
                    REG_IER:   n_read_data = {1'b1, r_enables};
                    REG_ORANH: n_read_data = pa_value;
                endcase
            end
            OP_WRITE: begin
                unique case (r_addr)
                    REG_ORB:   n_pb_latch = r_wdata;
                    REG_ORA:   n_pa_latch = r_wdata;
                    REG_DDRB:  n_pb_dir   = r_wdata;
                    REG_DDRA:  n_pa_dir   = r_wdata;
                    REG_T1CL:  n_t1_latch = {r_t1_latch[15:8], r_wdata};
                    REG_T1CH: begin
                        n_t1_latch       = {r_wdata, r_t1_latch[7:0]};
                        n_t1_count       = {r_wdata, r_t1_latch[7:0]};
                        n_t1_active      = 1'b1;
                        n_flags[FLAG_T1] = 1'b0;
                    end
                    REG_T1LL:  n_t1_latch = {r_t1_latch[15:8], r_wdata};
                    REG_T1LH:  n_t1_latch = {r_wdata, r_t1_latch[7:0]};
                    REG_T2CL:  n_t2_latch = {r_t2_latch[15:8], r_wdata};
                    REG_T2CH: begin
                        n_t2_latch       = {r_wdata, r_t2_latch[7:0]};
                        n_t2_count       = {r_wdata, r_t2_latch[7:0]};
                        n_t2_active      = 1'b1;
                        n_flags[FLAG_T2] = 1'b0;
                    end
                    REG_SR:    n_shift = r_wdata;
                    REG_ACR:   n_acr   = r_wdata;
                    REG_PCR:   n_pcr   = r_wdata;
                    REG_IFR:   n_flags = r_flags & ~r_wdata[6:0];
                    REG_IER: begin
                        if (r_wdata[7]) begin
                            n_enables = r_enables | r_wdata[6:0];
                        end else begin
                            n_enables = r_enables & ~r_wdata[6:0];
                        end
                    end
                    REG_ORANH: n_pa_latch = r_wdata;
                endcase
            end
            OP_TICK: begin
                // timer 1: reload in free-run mode, else wrap and keep going
                if (r_t1_active) begin
                    n_t1_count = r_t1_count - 16'd1;
                    if (r_t1_count == 16'd0) begin
                        n_flags[FLAG_T1] = 1'b1;
                        if (r_acr[ACR_T1_FREE]) begin
                            n_t1_count = r_t1_latch;
                        end
                    end
                end
                // timer 2: one shot, held while pulse counting is selected
                if (r_t2_active && !r_acr[ACR_T2_PULSE]) begin
                    n_t2_count = r_t2_count - 16'd1;
                    if (r_t2_count == 16'd0) begin
                        n_flags[FLAG_T2] = 1'b1;
                        n_t2_active      = 1'b0;
                    end
                end
            end
            OP_NONE: begin
                n_read_data = 8'h00;
            end
        endcase
    end

    assign pending = |(n_flags & n_enables);

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_op      <= i_operation;
            r_addr    <= i_address;
            r_wdata   <= i_write_data;
            r_pa_pins <= i_port_a_pins;
            r_pb_pins <= i_port_b_pins;
        end
    end

    // Register file and timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa_latch  <= BYTE_ONES;
            r_pb_latch  <= BYTE_ONES;
            r_pa_dir    <= '0;
            r_pb_dir    <= '0;
            r_t1_latch  <= WORD_ONES;
            r_t1_count  <= WORD_ONES;
            r_t2_latch  <= WORD_ONES;
            r_t2_count  <= WORD_ONES;
            r_t1_active <= 1'b0;
            r_t2_active <= 1'b0;
            r_shift     <= '0;
            r_acr       <= '0;
            r_pcr       <= '0;
            r_flags     <= '0;
            r_enables   <= '0;
        end else if (advance) begin
            r_pa_latch  <= n_pa_latch;
            r_pb_latch  <= n_pb_latch;
            r_pa_dir    <= n_pa_dir;
            r_pb_dir    <= n_pb_dir;
            r_t1_latch  <= n_t1_latch;
            r_t1_count  <= n_t1_count;
            r_t2_latch  <= n_t2_latch;
            r_t2_count  <= n_t2_count;
            r_t1_active <= n_t1_active;
            r_t2_active <= n_t2_active;
            r_shift     <= n_shift;
            r_acr       <= n_acr;
            r_pcr       <= n_pcr;
            r_flags     <= n_flags;
            r_enables   <= n_enables;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_read_data <= n_read_data;
            r_pa_drive  <= n_pa_latch & n_pa_dir;
            r_pb_drive  <= n_pb_latch & n_pb_dir;
            r_irq       <= pending;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_read_data    = r_read_data;
    assign o_port_a_drive = r_pa_drive;
    assign o_port_b_drive = r_pb_drive;
    assign o_irq          = r_irq;

endmodule

/* design/viatmr_chk.sv */
module viatmr_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_read_data,
    input logic [7:0] o_port_a_drive,
    input logic [7:0] o_port_b_drive,
    input logic       o_irq
);

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Input side only backs up behind a stalled result
    a_stall_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while result side is free");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    // A stalled result transaction holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_data) && $stable(o_irq)
            && $stable(o_port_a_drive) && $stable(o_port_b_drive))
        else $error("stalled result changed");

endmodule

bind via_timer_port_registers_top viatmr_chk u_viatmr_chk (.*);

/* dv/tb_via_timer_port_registers_top.sv */
module tb_via_timer_port_registers_top;
    import viatmr_pkg::*;

    // One bus transaction into the adapter and the response it produces
    typedef struct packed {
        logic [1:0] op;
        logic [3:0] addr;
        logic [7:0] data;
        logic [7:0] pa_pins;
        logic [7:0] pb_pins;
    } bus_txn_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] pa_drive;
        logic [7:0] pb_drive;
        logic       irq;
    } bus_resp_t;

    typedef struct packed {
        bus_txn_t  txn;
        logic      typed_in;
        bus_resp_t want;
    } directed_row_t;

    localparam int RANDOM_ITEMS = 1000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_operation = OP_NONE;
    logic [3:0] i_address = '0;
    logic [7:0] i_write_data = '0;
    logic [7:0] i_port_a_pins = BYTE_ONES;
    logic [7:0] i_port_b_pins = BYTE_ONES;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_read_data;
    logic [7:0] o_port_a_drive;
    logic [7:0] o_port_b_drive;
    logic       o_irq;

    via_timer_port_registers_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_port_a_pins  (i_port_a_pins),
        .i_port_b_pins  (i_port_b_pins),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_read_data    (o_read_data),
        .o_port_a_drive (o_port_a_drive),
        .o_port_b_drive (o_port_b_drive),
        .o_irq          (o_irq)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the adapter's register file and timers
    logic [7:0]  pa_latch, pb_latch, pa_dir, pb_dir;
    logic [15:0] t1_latch, t1_count, t2_latch, t2_count;
    logic        t1_running, t2_running;
    logic [7:0]  sr_byte, acr_reg, pcr_reg, ifr_reg;
    logic [6:0]  ier_reg;

    bus_resp_t expected_responses[$];
    int        mismatch_count = 0;
    int        results_seen = 0;
    int        sent_count = 0;
    bit        sender_steady = 1'b0;

    // Pins show through on input bits, the latch on output bits
    function automatic logic [7:0] port_level(logic [7:0] latch, logic [7:0] dir,
                                              logic [7:0] pins);
        return (latch & dir) | (pins & ~dir);
    endfunction

    // Advance the shadow state by one transaction and form its response
    task automatic predict_bus_cycle(input bus_txn_t t, output bus_resp_t r);
        logic [7:0]  rd;
        logic [15:0] prev;
        logic        pend;
        rd = '0;
        case (t.op)
            OP_READ: begin
                case (t.addr)
                    REG_ORB:   rd = port_level(pb_latch, pb_dir, t.pb_pins);
                    REG_DDRB:  rd = pb_dir;
                    REG_DDRA:  rd = pa_dir;
                    REG_T1CL: begin
                        ifr_reg[FLAG_T1] = 1'b0;
                        rd = t1_count[7:0];
                    end
                    REG_T1CH:  rd = t1_count[15:8];
                    REG_T1LL:  rd = t1_latch[7:0];
                    REG_T1LH:  rd = t1_latch[15:8];
                    REG_T2CL: begin
                        ifr_reg[FLAG_T2] = 1'b0;
                        rd = t2_count[7:0];
                    end
                    REG_T2CH:  rd = t2_count[15:8];
                    REG_SR:    rd = sr_byte;
                    REG_ACR:   rd = acr_reg;
                    REG_PCR:   rd = pcr_reg;
                    REG_IFR:   rd = ifr_reg;
                    REG_IER:   rd = {1'b1, ier_reg};
                    default:   rd = port_level(pa_latch, pa_dir, t.pa_pins);
                endcase
            end
            OP_WRITE: begin
                case (t.addr)
                    REG_ORB:   pb_latch = t.data;
                    REG_DDRB:  pb_dir = t.data;
                    REG_DDRA:  pa_dir = t.data;
                    REG_T1CL, REG_T1LL: t1_latch[7:0] = t.data;
                    REG_T1CH: begin
                        t1_latch[15:8] = t.data;
                        t1_count = t1_latch;
                        t1_running = 1'b1;
                        ifr_reg[FLAG_T1] = 1'b0;
                    end
                    REG_T1LH:  t1_latch[15:8] = t.data;
                    REG_T2CL:  t2_latch[7:0] = t.data;
                    REG_T2CH: begin
                        t2_latch[15:8] = t.data;
                        t2_count = t2_latch;
                        t2_running = 1'b1;
                        ifr_reg[FLAG_T2] = 1'b0;
                    end
                    REG_SR:    sr_byte = t.data;
                    REG_ACR:   acr_reg = t.data;
                    REG_PCR:   pcr_reg = t.data;
                    REG_IFR:   ifr_reg[6:0] = ifr_reg[6:0] & ~t.data[6:0];
                    REG_IER: begin
                        if (t.data[7]) begin
                            ier_reg = ier_reg | t.data[6:0];
                        end else begin
                            ier_reg = ier_reg & ~t.data[6:0];
                        end
                    end
                    default:   pa_latch = t.data;
                endcase
            end
            OP_TICK: begin
                // Timer 1 wraps or reloads on underflow and keeps running
                if (t1_running) begin
                    prev = t1_count;
                    t1_count = prev - 16'd1;
                    if (prev == 16'd0) begin
                        ifr_reg[FLAG_T1] = 1'b1;
                        if (acr_reg[ACR_T1_FREE]) t1_count = t1_latch;
                    end
                end
                // Timer 2 is one-shot and frozen while its ACR bit is set
                if (t2_running && !acr_reg[ACR_T2_PULSE]) begin
                    prev = t2_count;
                    t2_count = prev - 16'd1;
                    if (prev == 16'd0) begin
                        ifr_reg[FLAG_T2] = 1'b1;
                        t2_running = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        pend = |(ifr_reg[6:0] & ier_reg);
        ifr_reg[7] = pend;
        r.read_data = rd;
        r.pa_drive  = pa_latch & pa_dir;
        r.pb_drive  = pb_latch & pb_dir;
        r.irq       = pend;
    endtask

    function automatic bus_txn_t txn(logic [1:0] op, logic [3:0] addr, logic [7:0] data);
        bus_txn_t t;
        t.op      = op;
        t.addr    = addr;
        t.data    = data;
        t.pa_pins = ($urandom_range(0, 3) == 0) ? BYTE_ONES : 8'($urandom);
        t.pb_pins = ($urandom_range(0, 3) == 0) ? BYTE_ONES : 8'($urandom);
        return t;
    endfunction

    function automatic directed_row_t dir_row(logic [1:0] op, logic [3:0] addr,
                                              logic [7:0] data, logic [7:0] pa,
                                              logic [7:0] pb, logic typed,
                                              bus_resp_t want);
        directed_row_t row;
        row.txn      = '{op: op, addr: addr, data: data, pa_pins: pa, pb_pins: pb};
        row.typed_in = typed;
        row.want     = want;
        return row;
    endfunction

    // Offer one transaction, hold it through stalls, predict on acceptance
    task automatic send_transaction(input bus_txn_t t, input logic typed,
                                    input bus_resp_t want);
        bus_resp_t predicted;
        while (!sender_steady && $urandom_range(0, 99) < 17) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= t.op;
        i_address     <= t.addr;
        i_write_data  <= t.data;
        i_port_a_pins <= t.pa_pins;
        i_port_b_pins <= t.pb_pins;
        do @(posedge i_clk); while (o_stall);
        predict_bus_cycle(t, predicted);
        expected_responses.push_back(typed ? want : predicted);
        if (t.op != OP_NONE) sent_count++;
    endtask

    // Sender stops until every outstanding response has come back
    task automatic drain_responses();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_responses.size() != 0);
    endtask

    // Response checker and receiver stall pattern
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge i_clk) begin : result_check
        bus_resp_t got;
        bus_resp_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_read_data, o_port_a_drive, o_port_b_drive, o_irq};
            results_seen++;
            if (expected_responses.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected response: rd=%h pa=%h pb=%h irq=%b",
                             got.read_data, got.pa_drive, got.pb_drive, got.irq);
            end else begin
                want = expected_responses.pop_front();
                if (got.read_data !== want.read_data || got.pa_drive !== want.pa_drive ||
                    got.pb_drive !== want.pb_drive || got.irq !== want.irq) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"response %0d: expected rd=%h pa=%h pb=%h irq=%b, ",
                                  "got rd=%h pa=%h pb=%h irq=%b"},
                                 results_seen, want.read_data, want.pa_drive, want.pb_drive,
                                 want.irq, got.read_data, got.pa_drive, got.pb_drive, got.irq);
                end
            end
        end

        // Receiver stall: random, none while 500 to 650 results are seen, one long hold-off so the input side backs up
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!hold_done && results_seen >= 750) begin
            hold_done = 1'b1;
            hold_left = 40;
            i_stall <= 1'b1;
        end else if (results_seen >= 500 && results_seen < 650) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 17);
        end
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        directed_row_t directed_rows[$];
        bus_txn_t      t;
        int            pick;
        int            n;
        logic [7:0]    lo;
        logic [7:0]    hi;
        logic [3:0]    addr;
        bit            use_t2;
        bit            paused_once;

        // Shadow state at reset
        pa_latch   = BYTE_ONES;
        pb_latch   = BYTE_ONES;
        pa_dir     = '0;
        pb_dir     = '0;
        t1_latch   = WORD_ONES;
        t1_count   = WORD_ONES;
        t2_latch   = WORD_ONES;
        t2_count   = WORD_ONES;
        t1_running = 1'b0;
        t2_running = 1'b0;
        sr_byte    = '0;
        acr_reg    = '0;
        pcr_reg    = '0;
        ifr_reg    = '0;
        ier_reg    = '0;
        paused_once = 1'b0;

        // Directed rows: reset values, port direction mixing, timer corners
        directed_rows.push_back(dir_row(OP_READ, REG_DDRB, 8'h00, 8'h00, 8'h00, 1'b1,
                                        {8'h00, 8'h00, 8'h00, 1'b0}));
        directed_rows.push_back(dir_row(OP_READ, REG_ORB, 8'hFF, 8'h5A, 8'hA5, 1'b1,
                                        {8'hA5, 8'h00, 8'h00, 1'b0}));
        directed_rows.push_back(dir_row(OP_READ, REG_ORA, 8'h00, 8'h5A, 8'hA5, 1'b1,
                                        {8'h5A, 8'h00, 8'h00, 1'b0}));
        directed_rows.push_back(dir_row(OP_READ, REG_IER, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                                        {8'h80, 8'h00, 8'h00, 1'b0}));
        directed_rows.push_back(dir_row(OP_WRITE, REG_DDRA, 8'hFF, 8'h00, 8'h00, 1'b1,
                                        {8'h00, 8'hFF, 8'h00, 1'b0}));
        directed_rows.push_back(dir_row(OP_WRITE, REG_ORA, 8'h00, 8'hFF, 8'hFF, 1'b1,
                                        {8'h00, 8'h00, 8'h00, 1'b0}));
        directed_rows.push_back(dir_row(OP_WRITE, REG_DDRB, 8'hFF, 8'h00, 8'h00, 1'b1,
                                        {8'h00, 8'h00, 8'hFF, 1'b0}));
        directed_rows.push_back(dir_row(OP_WRITE, REG_ORB, 8'h81, 8'hFF, 8'hFF, 1'b1,
                                        {8'h00, 8'h00, 8'h81, 1'b0}));
        directed_rows.push_back(dir_row(OP_WRITE, REG_DDRA, 8'h0F, 8'h00, 8'h00, 1'b0, '0));
        directed_rows.push_back(dir_row(OP_READ, REG_ORA, 8'hFF, 8'hF0, 8'h00, 1'b0, '0));
        directed_rows.push_back(dir_row(OP_WRITE, REG_IER, 8'hFF, 8'h00, 8'hFF, 1'b0, '0));
        // Timer 1 loaded with a count of one, ticked through underflow; it wraps and raises irq
        directed_rows.push_back(dir_row(OP_WRITE, REG_T1LL, 8'h01, 8'hFF, 8'h00, 1'b0, '0));
        directed_rows.push_back(dir_row(OP_WRITE, REG_T1CH, 8'h00, 8'h00, 8'hFF, 1'b0, '0));
        directed_rows.push_back(dir_row(OP_TICK, REG_ORB, 8'h00, 8'hFF, 8'hFF, 1'b0, '0));
        directed_rows.push_back(dir_row(OP_TICK, REG_ORANH, 8'hFF, 8'h00, 8'h00, 1'b0, '0));
        directed_rows.push_back(dir_row(OP_READ, REG_IFR, 8'h00, 8'hFF, 8'hFF, 1'b0, '0));
        directed_rows.push_back(dir_row(OP_READ, REG_T1CL, 8'h00, 8'hFF, 8'hFF, 1'b0, '0));
        // Timer 2 held by the ACR bit, then released to underflow and stop
        directed_rows.push_back(dir_row(OP_WRITE, REG_ACR, 8'h60, 8'h00, 8'h00, 1'b0, '0));
        directed_rows.push_back(dir_row(OP_WRITE, REG_T2CL, 8'h01, 8'h00, 8'h00, 1'b0, '0));
        directed_rows.push_back(dir_row(OP_WRITE, REG_T2CH, 8'h00, 8'h00, 8'h00, 1'b0, '0));
        directed_rows.push_back(dir_row(OP_TICK, REG_ORB, 8'h00, 8'h00, 8'h00, 1'b0, '0));
        directed_rows.push_back(dir_row(OP_WRITE, REG_ACR, 8'h00, 8'h00, 8'h00, 1'b0, '0));
        directed_rows.push_back(dir_row(OP_TICK, REG_ORB, 8'h00, 8'h00, 8'h00, 1'b0, '0));
        directed_rows.push_back(dir_row(OP_TICK, REG_ORB, 8'h00, 8'h00, 8'h00, 1'b0, '0));
        directed_rows.push_back(dir_row(OP_WRITE, REG_IFR, 8'h7F, 8'h00, 8'h00, 1'b0, '0));
        directed_rows.push_back(dir_row(OP_WRITE, REG_IER, 8'h7F, 8'h00, 8'h00, 1'b0, '0));
        directed_rows.push_back(dir_row(OP_NONE, REG_ORANH, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_transaction(directed_rows[i].txn, directed_rows[i].typed_in,
                             directed_rows[i].want);
        drain_responses();

        // Random part: mostly well-formed timer, interrupt and port sequences
        sent_count = 0;
        while (sent_count < RANDOM_ITEMS) begin
            sender_steady = (sent_count >= 450 && sent_count < 600);
            if (!paused_once && sent_count >= 300) begin
                paused_once = 1'b1;
                drain_responses();
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // Program a mostly short count and tick it, sometimes through underflow
                use_t2 = 1'($urandom_range(0, 1));
                lo = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
                hi = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00;
                if ($urandom_range(0, 1))
                    send_transaction(txn(OP_WRITE, REG_ACR, 8'($urandom)), 1'b0, '0);
                if (use_t2) begin
                    send_transaction(txn(OP_WRITE, REG_T2CL, lo), 1'b0, '0);
                    send_transaction(txn(OP_WRITE, REG_T2CH, hi), 1'b0, '0);
                end else begin
                    addr = $urandom_range(0, 1) ? REG_T1CL : REG_T1LL;
                    send_transaction(txn(OP_WRITE, addr, lo), 1'b0, '0);
                    if ($urandom_range(0, 4) == 0)
                        send_transaction(txn(OP_WRITE, REG_T1LH, 8'($urandom)), 1'b0, '0);
                    send_transaction(txn(OP_WRITE, REG_T1CH, hi), 1'b0, '0);
                end
                n = $urandom_range(1, 14);
                repeat (n) begin
                    if ($urandom_range(0, 99) < 15) begin
                        case ($urandom_range(0, 4))
                            0:       addr = REG_T1CL;
                            1:       addr = REG_T2CL;
                            2:       addr = REG_IFR;
                            3:       addr = REG_T1CH;
                            default: addr = REG_T2CH;
                        endcase
                        send_transaction(txn(OP_READ, addr, 8'($urandom)), 1'b0, '0);
                    end else begin
                        send_transaction(txn(OP_TICK, 4'($urandom), 8'($urandom)), 1'b0, '0);
                    end
                end
            end else if (pick < 55) begin
                // Enable masks and flag clearing
                send_transaction(txn(OP_WRITE, REG_IER, 8'($urandom)), 1'b0, '0);
                send_transaction(txn(OP_READ, REG_IFR, 8'($urandom)), 1'b0, '0);
                if ($urandom_range(0, 1))
                    send_transaction(txn(OP_WRITE, REG_IFR, 8'($urandom)), 1'b0, '0);
                send_transaction(txn(OP_READ, REG_IER, 8'($urandom)), 1'b0, '0);
            end else if (pick < 75) begin
                // Direction, latch, then a read against random pins
                use_t2 = 1'($urandom_range(0, 1));
                lo = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? BYTE_ONES : 8'h00)
                                                 : 8'($urandom);
                send_transaction(txn(OP_WRITE, use_t2 ? REG_DDRA : REG_DDRB, lo), 1'b0, '0);
                if (use_t2)
                    addr = $urandom_range(0, 1) ? REG_ORA : REG_ORANH;
                else
                    addr = REG_ORB;
                send_transaction(txn(OP_WRITE, addr, 8'($urandom)), 1'b0, '0);
                send_transaction(txn(OP_READ, addr, 8'($urandom)), 1'b0, '0);
            end else begin
                t = txn(2'($urandom), 4'($urandom), 8'($urandom));
                send_transaction(t, 1'b0, '0);
            end
        end

        drain_responses();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_responses.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
